@@ src/mta_pkg.sv @@
package mta_pkg;

    // Matrix geometry and number format
    localparam int DIM       = 4;
    localparam int VW        = 32;
    localparam int FRAC_BITS = 16;
    localparam int ELEMS     = DIM * DIM;
    localparam int DIM_W     = $clog2(DIM);
    localparam int IDX_W     = 2 * DIM_W;
    localparam int SEQ_W     = 3 * DIM_W;
    localparam int PROD_W    = 2 * VW;
    localparam int SUM_W     = PROD_W + DIM_W;

    localparam logic [VW-1:0] FIX_ONE = VW'(1) << FRAC_BITS;
    localparam logic [VW-1:0] SAT_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0] SAT_MIN = {1'b1, {(VW-1){1'b0}}};

    // Tag that travels with one multiply-accumulate term
    typedef struct packed {
        logic             vld;
        logic             first;
        logic             last;
        logic             ident;
        logic             diag;
        logic [IDX_W-1:0] idx;
    } t_mac_tag;

    // Write-back of one product element into the accumulator memory
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] idx;
        logic [VW-1:0]    data;
    } t_acc_wr;

    // Drop the fraction bits and clamp the sum to the value range
    function automatic logic [VW-1:0] scale_sat(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0]     shifted;
        logic [SUM_W-FRAC_BITS-VW:0] top;
        shifted = s >>> FRAC_BITS;
        top     = shifted[SUM_W-FRAC_BITS-1:VW-1];
        if (top == '0 || top == '1) begin
            scale_sat = shifted[VW-1:0];
        end else if (s[SUM_W-1]) begin
            scale_sat = SAT_MIN;
        end else begin
            scale_sat = SAT_MAX;
        end
    endfunction

endpackage

@@ src/mta_in_if.sv @@
interface mta_in_if import mta_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic signed [VW-1:0] element_value;
    logic                 restart_chain;

    modport source (output valid, element_value, restart_chain, input ready);
    modport sink   (input valid, element_value, restart_chain, output ready);
endinterface

@@ src/mta_out_if.sv @@
interface mta_out_if import mta_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic signed [VW-1:0] product_value;
    logic [IDX_W-1:0]     product_index;
    logic                 last_element;

    modport source (output valid, product_value, product_index, last_element, input ready);
    modport sink   (input valid, product_value, product_index, last_element, output ready);
endinterface

@@ src/mta_term_mem.sv @@
module mta_term_mem import mta_pkg::*; (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  logic [VW-1:0]    i_wdata,
    input  logic             i_re,
    input  logic [IDX_W-1:0] i_raddr,
    output logic [VW-1:0]    o_rdata
);

    logic [VW-1:0] r_mem [ELEMS];
    logic [VW-1:0] r_rdata;

    // Store one term element per transfer
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/mta_acc_mem.sv @@
module mta_acc_mem import mta_pkg::*; (
    input  logic             i_clk,
    input  logic             i_wr_bank,
    input  t_acc_wr          i_wr,
    input  logic             i_re,
    input  logic             i_rd_bank,
    input  logic [IDX_W-1:0] i_raddr,
    output logic [VW-1:0]    o_rdata
);

    // Two banks: the current matrix is read from one, the product lands in the other
    logic [VW-1:0] r_mem [2*ELEMS];
    logic [VW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[{i_wr_bank, i_wr.idx}] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[{i_rd_bank, i_raddr}];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/mta_mac.sv @@
module mta_mac import mta_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  t_mac_tag         i_tag,
    input  logic [VW-1:0]    i_acc_rd,
    input  logic [VW-1:0]    i_term_rd,
    input  logic             i_out_ready,
    output logic             o_busy,
    output t_acc_wr          o_wr,
    output logic             o_out_valid,
    output logic [VW-1:0]    o_out_value,
    output logic [IDX_W-1:0] o_out_idx,
    output logic             o_out_last
);

    t_mac_tag                 r_c_tag;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [SUM_W-1:0]  n_sum;
    logic [VW-1:0]            a_val;
    logic [VW-1:0]            sat_val;
    logic                     r_out_valid;
    logic [VW-1:0]            r_out_value;
    logic [IDX_W-1:0]         r_out_idx;
    logic                     wr_fire;

    // Substitute identity for the accumulator on a restarted chain or after reset
    always_comb begin
        if (i_tag.ident) begin
            a_val = i_tag.diag ? FIX_ONE : '0;
        end else begin
            a_val = i_acc_rd;
        end
    end

    // Multiply stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_tag <= '0;
        end else if (i_adv) begin
            r_c_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_prod <= $signed(a_val) * $signed(i_term_rd);
        end
    end

    // Accumulate stage
    always_comb begin
        n_sum   = (r_c_tag.first ? SUM_W'(0) : r_sum)
                + {{DIM_W{r_prod[PROD_W-1]}}, r_prod};
        sat_val = scale_sat(n_sum);
        wr_fire = i_adv && r_c_tag.vld && r_c_tag.last;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && r_c_tag.vld) begin
            r_sum <= n_sum;
        end
    end

    // Output register: load a finished element, drop it once transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (wr_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_fire) begin
            r_out_value <= sat_val;
            r_out_idx   <= r_c_tag.idx;
        end
    end

    assign o_wr.we      = wr_fire;
    assign o_wr.idx     = r_c_tag.idx;
    assign o_wr.data    = sat_val;
    assign o_busy       = r_c_tag.vld;
    assign o_out_valid  = r_out_valid;
    assign o_out_value  = r_out_value;
    assign o_out_idx    = r_out_idx;
    assign o_out_last   = (r_out_idx == IDX_W'(ELEMS - 1));

endmodule

@@ src/mat4_transform_accumulate.sv @@
// Accumulating 4x4 transform in signed Q16.16: the sixteen elements of a term matrix arrive
// one per transfer in column-major order, and the sixteenth starts acc = acc * term; the
// sixteen product elements then leave in column-major order with the last one marked.
// restart_chain on the first element of a term restarts the chain from identity; the
// accumulator is identity after reset. Each product is the four-term sum shifted right by
// 16 and saturated to 32 bits. The multiply issues 64 terms, one accumulator read, one term
// read and one MAC per cycle while no output stall holds the pipeline; the read and multiply
// stages then drain. Inputs are refused while the multiply runs and until the pipeline has
// drained; output stalls freeze it.
module mat4_transform_accumulate import mta_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mta_in_if.sink    i_in,
    mta_out_if.source o_out
);

    logic [IDX_W-1:0] r_count;
    logic             r_restart;
    logic             r_acc_ident;
    logic             r_use_ident;
    logic             r_bank;
    logic             r_busy;
    logic [SEQ_W-1:0] r_seq;
    t_mac_tag         r_b_tag;
    t_mac_tag         a_tag;
    t_acc_wr          acc_wr;
    logic             in_fire;
    logic             adv;
    logic             issue;
    logic             mac_busy;
    logic             out_valid;
    logic [DIM_W-1:0] seq_k;
    logic [DIM_W-1:0] seq_row;
    logic [DIM_W-1:0] seq_col;
    logic [VW-1:0]    acc_rd;
    logic [VW-1:0]    term_rd;
    logic [VW-1:0]    out_value;

    // Freeze the whole pipeline while a result waits at the output
    assign adv     = !out_valid || o_out.ready;
    assign issue   = adv && r_busy;
    assign in_fire = i_in.valid && i_in.ready;

    assign i_in.ready = !r_busy && !r_b_tag.vld && !mac_busy;

    assign seq_k   = r_seq[DIM_W-1:0];
    assign seq_row = r_seq[2*DIM_W-1:DIM_W];
    assign seq_col = r_seq[SEQ_W-1:2*DIM_W];

    // Load counter, restart flag, run start and the term sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_restart   <= 1'b0;
            r_busy      <= 1'b0;
            r_use_ident <= 1'b0;
            r_seq       <= '0;
        end else begin
            if (in_fire) begin
                r_count <= r_count + IDX_W'(1);
                if (r_count == '0) begin
                    r_restart <= i_in.restart_chain;
                end
                if (r_count == IDX_W'(ELEMS - 1)) begin
                    r_busy      <= 1'b1;
                    r_use_ident <= r_acc_ident || r_restart;
                    r_restart   <= 1'b0;
                    r_seq       <= '0;
                end
            end else if (issue) begin
                r_seq <= r_seq + SEQ_W'(1);
                if (r_seq == '1) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Tag for the term issued this cycle
    always_comb begin
        a_tag.vld   = r_busy;
        a_tag.first = (seq_k == '0);
        a_tag.last  = (seq_k == '1);
        a_tag.ident = r_use_ident;
        a_tag.diag  = (seq_k == seq_row);
        a_tag.idx   = {seq_col, seq_row};
    end

    // Memory read stage tag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_tag <= '0;
        end else if (adv) begin
            r_b_tag <= a_tag;
        end
    end

    // Swap banks when the last product element is written back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank      <= 1'b0;
            r_acc_ident <= 1'b1;
        end else if (acc_wr.we && acc_wr.idx == IDX_W'(ELEMS - 1)) begin
            r_bank      <= !r_bank;
            r_acc_ident <= 1'b0;
        end
    end

    mta_term_mem u_term_mem (
        .i_clk   (i_clk),
        .i_we    (in_fire),
        .i_waddr (r_count),
        .i_wdata (i_in.element_value),
        .i_re    (issue),
        .i_raddr ({seq_col, seq_k}),
        .o_rdata (term_rd)
    );

    mta_acc_mem u_acc_mem (
        .i_clk     (i_clk),
        .i_wr_bank (!r_bank),
        .i_wr      (acc_wr),
        .i_re      (issue),
        .i_rd_bank (r_bank),
        .i_raddr   ({seq_k, seq_row}),
        .o_rdata   (acc_rd)
    );

    mta_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_tag       (r_b_tag),
        .i_acc_rd    (acc_rd),
        .i_term_rd   (term_rd),
        .i_out_ready (o_out.ready),
        .o_busy      (mac_busy),
        .o_wr        (acc_wr),
        .o_out_valid (out_valid),
        .o_out_value (out_value),
        .o_out_idx   (o_out.product_index),
        .o_out_last  (o_out.last_element)
    );

    assign o_out.valid         = out_valid;
    assign o_out.product_value = out_value;

endmodule

@@ tb/mat4_transform_accumulate_test.sv @@
module mat4_transform_accumulate_test;
    import mta_pkg::*;

    localparam int WIDE_W          = 2 * VW + 8;
    localparam int DIRECTED_ROWS   = 2 * ELEMS;
    localparam int RANDOM_MATRICES = 6;
    localparam int SETTLE_CYCLES   = 100;
    localparam int PRINT_LIMIT     = 40;

    // Range of a value after the fraction bits are dropped
    localparam logic signed [WIDE_W-1:0] FIT_HI =
        $signed({{(WIDE_W-VW+1){1'b0}}, {(VW-1){1'b1}}});
    localparam logic signed [WIDE_W-1:0] FIT_LO =
        $signed({{(WIDE_W-VW+1){1'b1}}, {(VW-1){1'b0}}});

    typedef enum int unsigned {STYLE_SMALL, STYLE_WIDE, STYLE_MIXED} t_elem_style;

    typedef struct packed {
        logic [VW-1:0]    value;
        logic [IDX_W-1:0] index;
        logic             last;
    } t_product;

    typedef struct packed {
        logic [VW-1:0] value;
        logic          restart;
        logic [VW-1:0] product;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mta_in_if  in_ch ();
    mta_out_if out_ch ();

    // Typed expectation that travels alongside a directed transfer
    logic          drive_typed;
    logic [VW-1:0] drive_typed_value;

    // Running model of the block
    logic signed [VW-1:0] chain_matrix [ELEMS];
    logic signed [VW-1:0] term_matrix  [ELEMS];
    logic [VW-1:0]        typed_product [ELEMS];
    logic                 typed_mask    [ELEMS];
    int unsigned          term_count;
    logic                 restart_armed;

    t_product    pending_products [$];
    int unsigned mismatch_count = 0;
    int unsigned ready_hold = 0;

    // First term: identity times the extremes, so each product equals its element.
    // Second term: twice identity without restart, so the chain doubles and the
    // extremes clamp; a restart flag off the first element must be ignored.
    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        '{32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
        '{32'h8000_0000, 1'b0, 32'h8000_0000},
        '{32'h0000_0000, 1'b0, 32'h0000_0000},
        '{32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF},
        '{32'h0000_0001, 1'b0, 32'h0000_0001},
        '{32'h0001_0000, 1'b0, 32'h0001_0000},
        '{32'hFFFF_0000, 1'b0, 32'hFFFF_0000},
        '{32'h4000_0000, 1'b0, 32'h4000_0000},
        '{32'hC000_0000, 1'b0, 32'hC000_0000},
        '{32'h3FFF_FFFF, 1'b0, 32'h3FFF_FFFF},
        '{32'hC000_0001, 1'b0, 32'hC000_0001},
        '{32'h5555_5555, 1'b0, 32'h5555_5555},
        '{32'hAAAA_AAAA, 1'b0, 32'hAAAA_AAAA},
        '{32'h0000_8000, 1'b0, 32'h0000_8000},
        '{32'h1234_5678, 1'b0, 32'h1234_5678},
        '{32'hEDCB_A988, 1'b0, 32'hEDCB_A988},
        '{32'h0002_0000, 1'b0, 32'h7FFF_FFFF},
        '{32'h0000_0000, 1'b0, 32'h8000_0000},
        '{32'h0000_0000, 1'b0, 32'h0000_0000},
        '{32'h0000_0000, 1'b0, 32'hFFFF_FFFE},
        '{32'h0000_0000, 1'b0, 32'h0000_0002},
        '{32'h0002_0000, 1'b1, 32'h0002_0000},
        '{32'h0000_0000, 1'b0, 32'hFFFE_0000},
        '{32'h0000_0000, 1'b0, 32'h7FFF_FFFF},
        '{32'h0000_0000, 1'b0, 32'h8000_0000},
        '{32'h0000_0000, 1'b0, 32'h7FFF_FFFE},
        '{32'h0002_0000, 1'b0, 32'h8000_0002},
        '{32'h0000_0000, 1'b0, 32'h7FFF_FFFF},
        '{32'h0000_0000, 1'b0, 32'h8000_0000},
        '{32'h0000_0000, 1'b0, 32'h0001_0000},
        '{32'h0000_0000, 1'b0, 32'h2468_ACF0},
        '{32'h0002_0000, 1'b0, 32'hDB97_5310}
    };

    mat4_transform_accumulate uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Count one mismatch and print it if no more than PRINT_LIMIT have been counted
    task automatic report_mismatch(input string what, input logic [VW-1:0] got,
                                   input logic [VW-1:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) begin
            $display("mismatch in %s: got %h, want %h at %0t", what, got, want, $time);
        end
    endtask

    // Clamp a value whose fraction is already dropped to the value range
    function automatic logic [VW-1:0] clamp_to_value(input logic signed [WIDE_W-1:0] x);
        if (x > FIT_HI) begin
            return SAT_MAX;
        end
        if (x < FIT_LO) begin
            return SAT_MIN;
        end
        return x[VW-1:0];
    endfunction

    task automatic load_chain_identity();
        for (int i = 0; i < ELEMS; i++) begin
            chain_matrix[i] = (i / DIM == i % DIM) ? FIX_ONE : '0;
        end
    endtask

    task automatic clear_model();
        load_chain_identity();
        for (int i = 0; i < ELEMS; i++) begin
            term_matrix[i] = '0;
            typed_mask[i]  = 1'b0;
        end
        term_count    = 0;
        restart_armed = 1'b0;
    endtask

    // Form chain = chain * term, from identity if a restart is armed, and queue the sixteen product elements
    task automatic multiply_into_chain();
        logic signed [VW-1:0]     next_chain [ELEMS];
        logic signed [WIDE_W-1:0] dot;
        t_product                 want;
        if (restart_armed) begin
            load_chain_identity();
        end
        restart_armed = 1'b0;
        for (int col = 0; col < DIM; col++) begin
            for (int row = 0; row < DIM; row++) begin
                dot = '0;
                for (int k = 0; k < DIM; k++) begin
                    dot = dot + chain_matrix[k*DIM+row] * term_matrix[col*DIM+k];
                end
                next_chain[col*DIM+row] = clamp_to_value(dot >>> FRAC_BITS);
            end
        end
        for (int idx = 0; idx < ELEMS; idx++) begin
            chain_matrix[idx] = next_chain[idx];
            want.value = typed_mask[idx] ? typed_product[idx] : next_chain[idx];
            want.index = IDX_W'(idx);
            want.last  = (idx == ELEMS - 1);
            pending_products.push_back(want);
            typed_mask[idx] = 1'b0;
        end
    endtask

    // Store one term element; the last one triggers the multiply
    task automatic absorb_term_element(input logic [VW-1:0] value, input logic restart,
                                       input logic typed, input logic [VW-1:0] typed_val);
        if (term_count == 0) begin
            restart_armed = restart;
        end
        term_matrix[term_count] = value;
        if (typed) begin
            typed_mask[term_count]    = 1'b1;
            typed_product[term_count] = typed_val;
        end
        if (term_count == ELEMS - 1) begin
            term_count = 0;
            multiply_into_chain();
        end else begin
            term_count++;
        end
    endtask

    // Compare one product transfer with the oldest expectation
    task automatic check_product();
        t_product want;
        if (pending_products.size() == 0) begin
            report_mismatch("product with none pending", out_ch.product_value, 'x);
        end else begin
            want = pending_products.pop_front();
            if (out_ch.product_value !== want.value) begin
                report_mismatch($sformatf("value at index %0d", want.index),
                                out_ch.product_value, want.value);
            end
            if (out_ch.product_index !== want.index) begin
                report_mismatch("index", VW'(out_ch.product_index), VW'(want.index));
            end
            if (out_ch.last_element !== want.last) begin
                report_mismatch($sformatf("last flag at index %0d", want.index),
                                VW'(out_ch.last_element), VW'(want.last));
            end
        end
    endtask

    // Watch both channels
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_model();
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                absorb_term_element(in_ch.element_value, in_ch.restart_chain,
                                    drive_typed, drive_typed_value);
            end
            if (out_ch.valid && out_ch.ready) begin
                check_product();
            end
        end
    end

    // Stall the product side: mostly short holds, a few long stalls and open stretches
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    out_ch.ready <= 1'b1;
                    ready_hold   <= $urandom_range(0, 6);
                end
                6, 7: begin
                    out_ch.ready <= 1'b0;
                    ready_hold   <= $urandom_range(0, 2);
                end
                8: begin
                    out_ch.ready <= 1'b0;
                    ready_hold   <= $urandom_range(8, 40);
                end
                default: begin
                    out_ch.ready <= 1'b1;
                    ready_hold   <= $urandom_range(20, 80);
                end
            endcase
        end
    end

    function automatic int unsigned idle_cycles();
        case ($urandom_range(0, 15))
            10, 11, 12, 13: return $urandom_range(1, 3);
            14:             return $urandom_range(4, 10);
            15:             return $urandom_range(15, 40);
            default:        return 0;
        endcase
    endfunction

    function automatic logic [VW-1:0] pick_element(input t_elem_style style);
        int unsigned   kind;
        logic [VW-1:0] small_val;
        kind      = $urandom_range(0, 9);
        // Uniform within plus or minus two
        small_val = VW'($urandom_range(0, 4 * FIX_ONE)) - 2 * FIX_ONE;
        case (style)
            STYLE_SMALL: return (kind == 0) ? '0 : small_val;
            STYLE_WIDE:  return $urandom();
            default: begin
                case (kind)
                    0, 1, 2, 3: return small_val;
                    4, 5:       return $urandom();
                    6:          return SAT_MAX;
                    7:          return SAT_MIN;
                    8:          return '0;
                    default:    return ($urandom_range(0, 1) != 0) ? FIX_ONE : -FIX_ONE;
                endcase
            end
        endcase
    endfunction

    // Offer one element after an optional gap and hold it until the transfer
    task automatic send_element(input logic [VW-1:0] value, input logic restart,
                                input logic typed, input logic [VW-1:0] product,
                                input bit burst);
        int unsigned gap;
        gap = burst ? 0 : idle_cycles();
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.element_value <= value;
        in_ch.restart_chain <= restart;
        drive_typed         <= typed;
        drive_typed_value   <= product;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Hold the sender until every queued product has arrived
    task automatic drain_products();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_products.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        t_elem_style style;
        bit          burst;
        logic        restart_flag;
        i_rst_n             <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.element_value <= '0;
        in_ch.restart_chain <= 1'b0;
        drive_typed         <= 1'b0;
        drive_typed_value   <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        foreach (directed_rows[r]) begin
            send_element(directed_rows[r].value, directed_rows[r].restart, 1'b1,
                         directed_rows[r].product, 1'b0);
        end
        drain_products();

        // Random term matrices, some sent back to back
        for (int m = 0; m < RANDOM_MATRICES; m++) begin
            style = t_elem_style'($urandom_range(0, 2));
            burst = ($urandom_range(0, 3) == 0);
            for (int e = 0; e < ELEMS; e++) begin
                restart_flag = (e == 0) ? ($urandom_range(0, 2) == 0)
                                        : ($urandom_range(0, 7) == 0);
                send_element(pick_element(style), restart_flag, 1'b0, '0, burst);
            end
            if (m == 3 || $urandom_range(0, 5) == 0) begin
                drain_products();
            end
        end

        drain_products();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("mat4_transform_accumulate test passed");
        end else begin
            $display("mat4_transform_accumulate test failed");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #5_000_000;
        $display("mat4_transform_accumulate test failed");
        $finish;
    end

endmodule

@@ filelist.f @@
src/mta_pkg.sv
src/mta_in_if.sv
src/mta_out_if.sv
src/mta_term_mem.sv
src/mta_acc_mem.sv
src/mta_mac.sv
src/mat4_transform_accumulate.sv
tb/mat4_transform_accumulate_test.sv
